// ===== rtl/fba_pkg.sv =====
// Package for the frame bitmap allocator: field widths, status and opcode codes,
// and the default geometry of the frame bitmap. No dependencies.
`timescale 1ns / 1ps

package fba_pkg;

   // Widths of the request, result and register fields.
   localparam int FRAME_W  = 13;
   localparam int FM_W     = 14;
   localparam int STATUS_W = 2;

   // Default bitmap geometry.
   localparam int NUM_FRAMES_DEF = 8192;
   localparam int WORD_BITS_DEF  = 32;

   // Reset value of the frames_managed register.
   localparam logic [FM_W-1:0] FM_RESET = 14'd8192;

   // Request opcodes.
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOP   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOMEM = 2'd2;

   typedef logic [STATUS_W-1:0] status_type;

endpackage

// ===== rtl/frame_bitmap_allocator.sv =====
// Frame bitmap allocator: first-fit page frame allocator over a bitmap memory.
// Depends on fba_pkg for field widths, codes and default geometry.
`timescale 1ns / 1ps

// Usage:
//   Request channel: drive req_* and raise start; the request is taken at a
//   rising edge where start is high and busy is low. One request is worked on
//   at a time. Busy drops in the cycle the result is on rsp_*, so the next
//   request can be taken at the edge that ends that cycle.
//   Result channel: rsp_valid is high for exactly one cycle with the updated
//   entry and status on rsp_*. The receiver cannot stall; the result must be
//   captured in that cycle.
//   Register port: csr_valid/csr_ready write frames_managed; csr_ready is
//   always high. Write it only while the block is idle.
//   Sequencing: an allocate on an entry that already holds a frame, or a free
//   of frame 0, answers in the cycle after acceptance. A free of a nonzero
//   frame splits into word and bit by shift and mask at acceptance (WORD_BITS
//   is a power of two); S_FREE_RD reads the bitmap word and S_FREE_WR writes
//   it back, while a frame beyond the bitmap answers from S_FREE_RD. An
//   allocate reads one bitmap word per cycle through the memory's read port.
//   Reset: the bitmap memory is cleared one word per cycle, and busy is high
//   while it is cleared.
module frame_bitmap_allocator #(
   parameter int NUM_FRAMES = fba_pkg::NUM_FRAMES_DEF,
   parameter int WORD_BITS  = fba_pkg::WORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // Request channel
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_opcode,
   input  logic                          req_entry_present,
   input  logic                          req_entry_writable,
   input  logic                          req_entry_user,
   input  logic [fba_pkg::FRAME_W-1:0]   req_entry_frame,
   input  logic                          req_kernel_only,
   input  logic                          req_make_writable,
   // Result channel
   output logic                          rsp_valid,
   output logic                          rsp_out_present,
   output logic                          rsp_out_writable,
   output logic                          rsp_out_user,
   output logic [fba_pkg::FRAME_W-1:0]   rsp_out_frame,
   output logic [fba_pkg::STATUS_W-1:0]  rsp_status,
   // Register write channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [fba_pkg::FM_W-1:0]      csr_data
);
   import fba_pkg::*;

   // Geometry.
   localparam int NWORDS   = NUM_FRAMES / WORD_BITS;
   localparam int MDEPTH   = (NWORDS > 1) ? NWORDS : 2;
   localparam int AW       = $clog2(MDEPTH);
   localparam int CNT_W    = $clog2(NWORDS + 1) + 1;
   localparam int BASE_W   = $clog2(NUM_FRAMES + WORD_BITS + 1);
   localparam int CMP_W    = ((BASE_W > FM_W) ? BASE_W : FM_W) + 1;
   localparam int OFF_W    = $clog2(WORD_BITS);
   localparam int IDX_W    = (CNT_W > FRAME_W) ? CNT_W : FRAME_W;
   localparam logic [CNT_W-1:0] NW_C     = CNT_W'(NWORDS);
   localparam logic [IDX_W-1:0] NW_I     = IDX_W'(NWORDS);
   localparam logic [AW-1:0]    CLR_LAST = AW'(MDEPTH - 1);
   localparam logic [WORD_BITS-1:0] ONE_W = {{(WORD_BITS-1){1'b0}}, 1'b1};

   // Sequencer states.
   localparam logic [2:0] S_CLEAR   = 3'd0;
   localparam logic [2:0] S_IDLE    = 3'd1;
   localparam logic [2:0] S_SCAN    = 3'd2;
   localparam logic [2:0] S_FREE_RD = 3'd4;
   localparam logic [2:0] S_FREE_WR = 3'd5;

   // Control registers.
   logic [2:0]           state_ff, state_in;
   logic [AW-1:0]        clr_cnt_ff, clr_cnt_in;
   logic [FM_W-1:0]      fm_ff, fm_in;
   logic [CNT_W-1:0]     iss_addr_ff, iss_addr_in;
   logic [BASE_W-1:0]    iss_base_ff, iss_base_in;
   logic                 chk_valid_ff, chk_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Payload registers.
   logic [AW-1:0]        chk_addr_ff, chk_addr_in;
   logic [BASE_W-1:0]    chk_base_ff, chk_base_in;
   logic                 rq_present_ff, rq_present_in;
   logic                 rq_writable_ff, rq_writable_in;
   logic                 rq_user_ff, rq_user_in;
   logic                 rq_kernel_ff, rq_kernel_in;
   logic                 rq_wr_ff, rq_wr_in;
   logic [FRAME_W-1:0]   quo_ff, quo_in;
   logic [OFF_W-1:0]     rem_ff, rem_in;
   logic                 rsp_present_ff, rsp_present_in;
   logic                 rsp_writable_ff, rsp_writable_in;
   logic                 rsp_user_ff, rsp_user_in;
   logic [FRAME_W-1:0]   rsp_frame_ff, rsp_frame_in;
   status_type           rsp_status_ff, rsp_status_in;

   // Bitmap memory and its ports.
   logic [WORD_BITS-1:0] bitmap_mem [MDEPTH];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic [AW-1:0]        mem_ra;
   logic                 mem_we;
   logic [AW-1:0]        mem_wa;
   logic [WORD_BITS-1:0] mem_wd;

   // Helper signals.
   logic                 accept;
   logic                 free_found;
   logic [OFF_W-1:0]     free_bit;
   logic                 found;
   logic                 in_range;
   logic [BASE_W-1:0]    new_frame;
   logic [IDX_W-1:0]     quo_wide;
   logic                 quo_in_map;

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   // Lowest zero bit of the word just read.
   always_comb begin
      free_found = 1'b0;
      free_bit   = '0;
      for (int k = WORD_BITS - 1; k >= 0; k--) begin
         if (!rd_data_ff[k]) begin
            free_found = 1'b1;
            free_bit   = OFF_W'(k);
         end
      end
   end

   // Scan bookkeeping: a word is searched only while it lies wholly below
   // frames_managed and inside the bitmap.
   assign found     = (state_ff == S_SCAN) && chk_valid_ff && free_found;
   assign in_range  = ((CMP_W'(iss_base_ff) + CMP_W'(WORD_BITS)) <= CMP_W'(fm_ff))
                      && (iss_addr_ff < NW_C);
   assign new_frame = chk_base_ff + BASE_W'(free_bit);

   // Word index of the frame being freed, and whether that word exists.
   assign quo_wide   = IDX_W'(quo_ff);
   assign quo_in_map = (quo_wide < NW_I);

   // Memory address and write selection.
   always_comb begin
      mem_ra = iss_addr_ff[AW-1:0];
      mem_we = 1'b0;
      mem_wa = clr_cnt_ff;
      mem_wd = '0;
      unique case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
         end
         S_SCAN: begin
            mem_we = found;
            mem_wa = chk_addr_ff;
            mem_wd = rd_data_ff | (ONE_W << free_bit);
         end
         S_FREE_RD: begin
            mem_ra = quo_wide[AW-1:0];
         end
         S_FREE_WR: begin
            mem_we = 1'b1;
            mem_wa = quo_wide[AW-1:0];
            mem_wd = rd_data_ff & ~(ONE_W << rem_ff);
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   // Sequencer and datapath next values.
   always_comb begin
      state_in        = state_ff;
      clr_cnt_in      = clr_cnt_ff;
      fm_in           = fm_ff;
      iss_addr_in     = iss_addr_ff;
      iss_base_in     = iss_base_ff;
      chk_valid_in    = 1'b0;
      chk_addr_in     = chk_addr_ff;
      chk_base_in     = chk_base_ff;
      rq_present_in   = rq_present_ff;
      rq_writable_in  = rq_writable_ff;
      rq_user_in      = rq_user_ff;
      rq_kernel_in    = rq_kernel_ff;
      rq_wr_in        = rq_wr_ff;
      quo_in          = quo_ff;
      rem_in          = rem_ff;
      rsp_valid_in    = 1'b0;
      rsp_present_in  = rsp_present_ff;
      rsp_writable_in = rsp_writable_ff;
      rsp_user_in     = rsp_user_ff;
      rsp_frame_in    = rsp_frame_ff;
      rsp_status_in   = rsp_status_ff;

      if (csr_valid && csr_ready) begin
         fm_in = csr_data;
      end

      unique case (state_ff)
         S_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == CLR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               rq_present_in   = req_entry_present;
               rq_writable_in  = req_entry_writable;
               rq_user_in      = req_entry_user;
               rq_kernel_in    = req_kernel_only;
               rq_wr_in        = req_make_writable;
               // Default result: the entry as given, nothing done.
               rsp_present_in  = req_entry_present;
               rsp_writable_in = req_entry_writable;
               rsp_user_in     = req_entry_user;
               rsp_frame_in    = req_entry_frame;
               rsp_status_in   = ST_NOP;
               if (req_entry_frame != '0) begin
                  if (req_opcode == OP_FREE) begin
                     // Split the frame into word index and bit offset.
                     quo_in   = req_entry_frame >> OFF_W;
                     rem_in   = req_entry_frame[OFF_W-1:0];
                     state_in = S_FREE_RD;
                  end else begin
                     rsp_valid_in = 1'b1;
                  end
               end else if (req_opcode == OP_ALLOC) begin
                  iss_addr_in = '0;
                  iss_base_in = '0;
                  state_in    = S_SCAN;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         S_SCAN: begin
            if (found) begin
               rsp_present_in  = 1'b1;
               rsp_writable_in = rq_wr_ff;
               rsp_user_in     = !rq_kernel_ff;
               rsp_frame_in    = FRAME_W'(new_frame);
               rsp_status_in   = ST_DONE;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end else if (in_range) begin
               // Read the next word; it is checked in the following cycle.
               chk_valid_in = 1'b1;
               chk_addr_in  = iss_addr_ff[AW-1:0];
               chk_base_in  = iss_base_ff;
               iss_addr_in  = iss_addr_ff + CNT_W'(1);
               iss_base_in  = iss_base_ff + BASE_W'(WORD_BITS);
            end else begin
               rsp_status_in = ST_NOMEM;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_FREE_RD: begin
            // The frame number is cleared whether or not it lies in the bitmap.
            rsp_present_in  = rq_present_ff;
            rsp_writable_in = rq_writable_ff;
            rsp_user_in     = rq_user_ff;
            rsp_frame_in    = '0;
            rsp_status_in   = ST_DONE;
            if (quo_in_map) begin
               state_in = S_FREE_WR;
            end else begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_FREE_WR: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         fm_ff        <= FM_RESET;
         iss_addr_ff  <= '0;
         iss_base_ff  <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         fm_ff        <= fm_in;
         iss_addr_ff  <= iss_addr_in;
         iss_base_ff  <= iss_base_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      chk_addr_ff     <= chk_addr_in;
      chk_base_ff     <= chk_base_in;
      rq_present_ff   <= rq_present_in;
      rq_writable_ff  <= rq_writable_in;
      rq_user_ff      <= rq_user_in;
      rq_kernel_ff    <= rq_kernel_in;
      rq_wr_ff        <= rq_wr_in;
      quo_ff          <= quo_in;
      rem_ff          <= rem_in;
      rsp_present_ff  <= rsp_present_in;
      rsp_writable_ff <= rsp_writable_in;
      rsp_user_ff     <= rsp_user_in;
      rsp_frame_ff    <= rsp_frame_in;
      rsp_status_ff   <= rsp_status_in;
   end

   // Bitmap memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         bitmap_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= bitmap_mem[mem_ra];
   end

   // Outputs.
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_present  = rsp_present_ff;
   assign rsp_out_writable = rsp_writable_ff;
   assign rsp_out_user     = rsp_user_ff;
   assign rsp_out_frame    = rsp_frame_ff;
   assign rsp_status       = rsp_status_ff;

`ifndef NO_ASSERTIONS
   // The bitmap is only written by the clear pass or by a request in progress.
   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff != S_IDLE))
      else $error("bitmap written while idle");

   // A free bit found in the scan gives a done result in the next cycle.
   a_found_done: assert property (@(posedge clock) disable iff (reset)
      found |=> (rsp_valid && rsp_status == ST_DONE && rsp_out_present))
      else $error("found frame not reported as done");

   // A free that reaches the write-back stage writes the bitmap.
   a_free_writes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FREE_WR) |-> (mem_we && quo_in_map))
      else $error("free write-back missing");

   // A no-memory result leaves the frame number as it was given.
   a_nomem_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_NOMEM) |-> (rsp_out_frame == '0))
      else $error("no-memory result carries a frame");
`endif

endmodule
